// ----- rtl/lse_pkg.sv -----
`default_nettype none

package lse_pkg;

    localparam int LSE_INDEX_BITS = 24;
    localparam int IDX_OUT_W      = 24;
    localparam int APB_ADDR_W     = 5;
    localparam int APB_DATA_W     = 32;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_CHANNEL_COUNT  = 3'd0;
    localparam logic [2:0] REG_FIRST_CHANNEL  = 3'd1;
    localparam logic [2:0] REG_SECOND_CHANNEL = 3'd2;
    localparam logic [2:0] REG_THIRD_CHANNEL  = 3'd3;
    localparam logic [2:0] REG_ROW_PIXELS     = 3'd4;

    // extraction phase codes
    localparam logic [1:0] PH_FIRST_ROW = 2'd0;
    localparam logic [1:0] PH_ACCEPTED  = 2'd1;
    localparam logic [1:0] PH_REJECTED  = 2'd2;

    // file kind codes
    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_JPEG = 3'd1;
    localparam logic [2:0] KIND_MP3  = 3'd2;
    localparam logic [2:0] KIND_BMP  = 3'd3;
    localparam logic [2:0] KIND_PDF  = 3'd4;
    localparam logic [2:0] KIND_DOCX = 3'd5;

    // leading byte signatures, byte zero in the low bits
    localparam logic [23:0] SIG_JPEG = 24'hFFD8FF;
    localparam logic [23:0] SIG_MP3  = 24'h334449;
    localparam logic [15:0] SIG_BMP  = 16'h4D42;
    localparam logic [31:0] SIG_PDF  = 32'h46445025;
    localparam logic [31:0] SIG_DOCX = 32'h04034B50;

    typedef struct packed {
        logic [1:0]  channel_count;
        logic [1:0]  first_channel;
        logic [1:0]  second_channel;
        logic [1:0]  third_channel;
        logic [15:0] row_pixels;
    } t_cfg;

    typedef struct packed {
        logic       image_start;
        logic [7:0] pixel_byte_two;
        logic [7:0] pixel_byte_one;
        logic [7:0] pixel_byte_zero;
    } t_pixel;

    typedef struct packed {
        logic [2:0]           file_kind;
        logic                 decision_valid;
        logic [IDX_OUT_W-1:0] byte_index;
        logic [7:0]           extracted_byte;
        logic                 byte_valid;
    } t_result;

    function automatic logic chan_bit(input t_pixel pix, input logic [1:0] sel);
        logic b;
        case (sel)
            2'd0:    b = pix.pixel_byte_zero[0];
            2'd1:    b = pix.pixel_byte_one[0];
            default: b = pix.pixel_byte_two[0];
        endcase
        return b;
    endfunction

    function automatic logic [2:0] sig_match(input logic [31:0] lead);
        logic [2:0] k;
        if (lead[23:0] == SIG_JPEG) begin
            k = KIND_JPEG;
        end else if (lead[23:0] == SIG_MP3) begin
            k = KIND_MP3;
        end else if (lead[15:0] == SIG_BMP) begin
            k = KIND_BMP;
        end else if (lead == SIG_PDF) begin
            k = KIND_PDF;
        end else if (lead == SIG_DOCX) begin
            k = KIND_DOCX;
        end else begin
            k = KIND_NONE;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/lsb_stego_extractor_unit.sv -----
`default_nettype none

// channel    | direction | accepted when                      | payload
// s_axis     | in        | s_axis_tvalid & s_axis_tready      | one pixel, image start in tuser
// m_axis     | out       | m_axis_tvalid & m_axis_tready      | byte and/or header decision
// apb        | in        | psel & penable & pwrite & pready   | register write, 4-byte stride
//
// one pixel per cycle sustained while results are taken; a pixel is held in the input register,
// then the extractor updates its state and loads the result register.
// reset (synchronous, active low) clears registers to their defaults and the
// extraction state to an empty first row.
// a stalled result only blocks pixels that produce a result; others still drain.

module lsb_stego_extractor_unit #(
    parameter int INDEX_BITS = lse_pkg::LSE_INDEX_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // pixel input
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] pixel_byte_zero, [15:8] pixel_byte_one, [23:16] pixel_byte_two
    input  wire logic [23:0]                    s_axis_tdata,
    // [0] image_start
    input  wire logic [0:0]                     s_axis_tuser,
    // result output
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [7:0] extracted_byte, [31:8] byte_index
    output logic      [31:0]                    m_axis_tdata,
    // [0] byte_valid, [1] decision_valid, [4:2] file_kind
    output logic      [4:0]                     m_axis_tuser,
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lse_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [lse_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [lse_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);
    import lse_pkg::*;

    t_cfg    w_cfg;
    t_pixel  r_pixel;
    logic    r_in_valid;
    t_result r_result;
    logic    r_out_valid;
    t_result w_result;
    logic    w_has_result;
    logic    w_advance;
    logic    w_in_fire;

    lse_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lse_extract #(
        .INDEX_BITS (INDEX_BITS)
    ) u_extract (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_pixel      (r_pixel),
        .i_advance    (w_advance),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    // held pixel moves on when its result (if any) has room
    assign w_advance     = r_in_valid && (!w_has_result || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_pixel.pixel_byte_zero <= s_axis_tdata[7:0];
            r_pixel.pixel_byte_one  <= s_axis_tdata[15:8];
            r_pixel.pixel_byte_two  <= s_axis_tdata[23:16];
            r_pixel.image_start     <= s_axis_tuser[0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_has_result) begin
            r_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_result.byte_index, r_result.extracted_byte};
    assign m_axis_tuser  = {r_result.file_kind, r_result.decision_valid, r_result.byte_valid};

`ifndef SYNTHESIS
    a_result_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.byte_valid || r_result.decision_valid))
        else $error("result item carries neither byte nor decision");

    a_kind_only_on_decision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_result.decision_valid) |-> (r_result.file_kind == KIND_NONE))
        else $error("file kind without decision");

    a_byte_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_result.byte_valid)
            |-> (r_result.extracted_byte == 8'd0 && r_result.byte_index == '0))
        else $error("byte fields set without a byte");
`endif

endmodule

`default_nettype wire

// ----- rtl/lse_cfg_regs.sv -----
`default_nettype none

module lse_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lse_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [lse_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [lse_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output lse_pkg::t_cfg                       o_cfg
);
    import lse_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_count  <= 2'd1;
            r_cfg.first_channel  <= 2'd0;
            r_cfg.second_channel <= 2'd1;
            r_cfg.third_channel  <= 2'd2;
            r_cfg.row_pixels     <= 16'd1;
        end else if (w_wr) begin
            case (w_idx)
                REG_CHANNEL_COUNT:  r_cfg.channel_count  <= pwdata[1:0];
                REG_FIRST_CHANNEL:  r_cfg.first_channel  <= pwdata[1:0];
                REG_SECOND_CHANNEL: r_cfg.second_channel <= pwdata[1:0];
                REG_THIRD_CHANNEL:  r_cfg.third_channel  <= pwdata[1:0];
                REG_ROW_PIXELS:     r_cfg.row_pixels     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_CHANNEL_COUNT:  prdata = {30'd0, r_cfg.channel_count};
            REG_FIRST_CHANNEL:  prdata = {30'd0, r_cfg.first_channel};
            REG_SECOND_CHANNEL: prdata = {30'd0, r_cfg.second_channel};
            REG_THIRD_CHANNEL:  prdata = {30'd0, r_cfg.third_channel};
            REG_ROW_PIXELS:     prdata = {16'd0, r_cfg.row_pixels};
            default:            prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/lse_extract.sv -----
`default_nettype none

module lse_extract #(
    parameter int INDEX_BITS = lse_pkg::LSE_INDEX_BITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire lse_pkg::t_cfg    i_cfg,
    input  wire lse_pkg::t_pixel  i_pixel,
    input  wire logic             i_advance,
    output logic                  o_has_result,
    output lse_pkg::t_result      o_result
);
    import lse_pkg::*;

    // extraction state
    logic [7:0]            r_acc;
    logic [2:0]            r_held;
    logic [INDEX_BITS-1:0] r_done;
    logic [3:0][7:0]       r_lead;
    logic [2:0]            r_lead_cnt;
    logic [15:0]           r_pix;
    logic [1:0]            r_phase;

    logic [7:0]            n_acc;
    logic [2:0]            n_held;
    logic [INDEX_BITS-1:0] n_done;
    logic [3:0][7:0]       n_lead;
    logic [2:0]            n_lead_cnt;
    logic [15:0]           n_pix;
    logic [1:0]            n_phase;

    logic [7:0]            c_acc;
    logic [2:0]            c_held;
    logic [INDEX_BITS-1:0] c_done;
    logic [3:0][7:0]       c_lead;
    logic [2:0]            c_lead_cnt;
    logic [15:0]           c_pix;
    logic [1:0]            c_phase;

    logic [1:0]  w_cnt;
    logic        w_b0, w_b1, w_b2;
    logic [10:0] w_shift;
    logic [3:0]  w_total;
    logic [1:0]  w_rem;
    logic [7:0]  w_byte;
    logic [15:0] w_rows;
    logic [2:0]  w_kind;

    always_comb begin
        // image start clears everything before the pixel is used
        if (i_pixel.image_start) begin
            c_acc      = '0;
            c_held     = '0;
            c_done     = '0;
            c_lead     = '0;
            c_lead_cnt = '0;
            c_pix      = '0;
            c_phase    = PH_FIRST_ROW;
        end else begin
            c_acc      = r_acc;
            c_held     = r_held;
            c_done     = r_done;
            c_lead     = r_lead;
            c_lead_cnt = r_lead_cnt;
            c_pix      = r_pix;
            c_phase    = r_phase;
        end

        n_acc      = c_acc;
        n_held     = c_held;
        n_done     = c_done;
        n_lead     = c_lead;
        n_lead_cnt = c_lead_cnt;
        n_pix      = c_pix;
        n_phase    = c_phase;

        o_result     = '0;
        o_has_result = 1'b0;

        w_cnt   = (i_cfg.channel_count == 2'd0) ? 2'd1 : i_cfg.channel_count;
        w_b0    = chan_bit(i_pixel, i_cfg.first_channel);
        w_b1    = chan_bit(i_pixel, i_cfg.second_channel);
        w_b2    = chan_bit(i_pixel, i_cfg.third_channel);
        w_shift = {3'd0, c_acc};
        case (w_cnt)
            2'd2:    w_shift = {w_shift[8:0], w_b0, w_b1};
            2'd3:    w_shift = {w_shift[7:0], w_b0, w_b1, w_b2};
            default: w_shift = {w_shift[9:0], w_b0};
        endcase
        w_total = {1'b0, c_held} + {2'd0, w_cnt};
        w_rem   = w_total[1:0];
        w_byte  = 8'(w_shift >> w_rem);
        w_rows  = (i_cfg.row_pixels == 16'd0) ? 16'd1 : i_cfg.row_pixels;
        w_kind  = KIND_NONE;

        if (c_phase != PH_REJECTED) begin
            if (w_total[3]) begin
                // byte done, leftover bits (0..2) start the next one
                n_acc                   = w_shift[7:0] & ~(8'hFF << w_rem);
                n_held                  = {1'b0, w_rem};
                n_done                  = c_done + 1'b1;
                o_result.byte_valid     = 1'b1;
                o_result.extracted_byte = w_byte;
                o_result.byte_index     = IDX_OUT_W'(c_done);
                o_has_result            = 1'b1;
                if (c_lead_cnt < 3'd4) begin
                    n_lead[c_lead_cnt[1:0]] = w_byte;
                    n_lead_cnt              = c_lead_cnt + 3'd1;
                end
            end else begin
                n_acc  = w_shift[7:0];
                n_held = w_total[2:0];
            end

            if (c_phase == PH_FIRST_ROW) begin
                n_pix = c_pix + 16'd1;
                if (n_pix >= w_rows) begin
                    w_kind                  = sig_match(n_lead);
                    n_phase                 = (w_kind != KIND_NONE) ? PH_ACCEPTED : PH_REJECTED;
                    o_result.decision_valid = 1'b1;
                    o_result.file_kind      = w_kind;
                    o_has_result            = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_held     <= '0;
            r_done     <= '0;
            r_lead     <= '0;
            r_lead_cnt <= '0;
            r_pix      <= '0;
            r_phase    <= PH_FIRST_ROW;
        end else if (i_advance) begin
            r_acc      <= n_acc;
            r_held     <= n_held;
            r_done     <= n_done;
            r_lead     <= n_lead;
            r_lead_cnt <= n_lead_cnt;
            r_pix      <= n_pix;
            r_phase    <= n_phase;
        end
    end

`ifndef SYNTHESIS
    a_rejected_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_REJECTED && !i_pixel.image_start) |-> !o_has_result)
        else $error("rejected image produced a result");

    a_lead_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lead_cnt <= 3'd4)
        else $error("leading byte count overflow");

    a_leftover_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.byte_valid |-> (n_held <= 3'd2))
        else $error("too many bits left after a completed byte");
`endif

endmodule

`default_nettype wire

// ----- test/tb_lsb_stego_extractor_unit.sv -----
`timescale 1ns / 100ps

module tb_lsb_stego_extractor_unit;

    import lse_pkg::*;

    localparam int CLK_HALF_NS   = 6;
    localparam int RESET_CYCLES  = 9;
    // drain time through the input and result registers, plus margin for pixels that leave no result
    localparam int DRAIN_CYCLES  = 4;
    localparam int END_WAIT      = 4000;
    localparam int MAX_REPORTS   = 10;
    localparam int HOLD_CYCLES   = 400;
    localparam int TIMEOUT_NS    = 3_000_000;

    // directed table: register writes and pixels, some with a hand-typed result
    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_PIXEL,
        ROW_TYPED
    } t_row_op;

    typedef struct packed {
        t_row_op     op;
        logic [2:0]  reg_idx;
        logic [15:0] value;
        logic        start;
        logic [23:0] data;
        logic [4:0]  exp_user;   // {file_kind, decision_valid, byte_valid}
    } t_dir_row;

    localparam int DIR_ROWS = 30;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        // reset settings: one bit per pixel, one-pixel row, so the very first
        // pixel decides on all-zero leading bytes and rejects the image
        '{ROW_TYPED, 3'd0, 16'd0, 1'b0, 24'h000000, {KIND_NONE, 1'b1, 1'b0}},
        // rejected image, pixel ignored
        '{ROW_PIXEL, 3'd0, 16'd0, 1'b0, 24'hFFFFFF, 5'd0},
        '{ROW_WRITE, REG_CHANNEL_COUNT, 16'd3, 1'b0, 24'h0, 5'd0},
        '{ROW_WRITE, REG_ROW_PIXELS, 16'd11, 1'b0, 24'h0, 5'd0},
        // jpeg header ff d8 ff 49, three bits per pixel in channel order 0 1 2
        '{ROW_PIXEL, 3'd0, 16'd0, 1'b1, 24'hFFFFFF, 5'd0},
        '{ROW_PIXEL, 3'd0, 16'd0, 1'b0, 24'h812345, 5'd0},
        '{ROW_PIXEL, 3'd0, 16'd0, 1'b0, 24'h010101, 5'd0},
        '{ROW_PIXEL, 3'd0, 16'd0, 1'b0, 24'hFFFEFF, 5'd0},
        '{ROW_PIXEL, 3'd0, 16'd0, 1'b0, 24'hFEFE01, 5'd0},
        '{ROW_PIXEL, 3'd0, 16'd0, 1'b0, 24'h0101FE, 5'd0},
        '{ROW_PIXEL, 3'd0, 16'd0, 1'b0, 24'h7F7F7F, 5'd0},
        '{ROW_PIXEL, 3'd0, 16'd0, 1'b0, 24'hFFFFFF, 5'd0},
        '{ROW_PIXEL, 3'd0, 16'd0, 1'b0, 24'hAA55AA, 5'd0},
        '{ROW_PIXEL, 3'd0, 16'd0, 1'b0, 24'h000100, 5'd0},
        // fourth byte completes together with the header decision
        '{ROW_PIXEL, 3'd0, 16'd0, 1'b0, 24'h8101FE, 5'd0},
        // accepted image, half a byte only, no result
        '{ROW_PIXEL, 3'd0, 16'd0, 1'b0, 24'h000000, 5'd0},
        // zero channel count, selector three, zero row length
        '{ROW_WRITE, REG_CHANNEL_COUNT, 16'd0, 1'b0, 24'h0, 5'd0},
        '{ROW_WRITE, REG_FIRST_CHANNEL, 16'd3, 1'b0, 24'h0, 5'd0},
        '{ROW_WRITE, REG_ROW_PIXELS, 16'd0, 1'b0, 24'h0, 5'd0},
        '{ROW_TYPED, 3'd0, 16'd0, 1'b1, 24'h010000, {KIND_NONE, 1'b1, 1'b0}},
        '{ROW_PIXEL, 3'd0, 16'd0, 1'b0, 24'hFFFFFF, 5'd0},
        '{ROW_TYPED, 3'd0, 16'd0, 1'b1, 24'hFE0000, {KIND_NONE, 1'b1, 1'b0}},
        // permuted channels, short row: the rejecting pixel still carries a byte
        '{ROW_WRITE, REG_CHANNEL_COUNT, 16'd3, 1'b0, 24'h0, 5'd0},
        '{ROW_WRITE, REG_FIRST_CHANNEL, 16'd2, 1'b0, 24'h0, 5'd0},
        '{ROW_WRITE, REG_SECOND_CHANNEL, 16'd0, 1'b0, 24'h0, 5'd0},
        '{ROW_WRITE, REG_THIRD_CHANNEL, 16'd3, 1'b0, 24'h0, 5'd0},
        '{ROW_WRITE, REG_ROW_PIXELS, 16'd3, 1'b0, 24'h0, 5'd0},
        '{ROW_PIXEL, 3'd0, 16'd0, 1'b1, 24'h5A5A5A, 5'd0},
        '{ROW_PIXEL, 3'd0, 16'd0, 1'b0, 24'hA5A5A5, 5'd0},
        '{ROW_PIXEL, 3'd0, 16'd0, 1'b0, 24'h123456, 5'd0}
    };

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [7:0] pixel_byte_zero, [15:8] pixel_byte_one, [23:16] pixel_byte_two
    logic [23:0]           s_axis_tdata  = '0;
    // [0] image_start
    logic [0:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [7:0] extracted_byte, [31:8] byte_index
    logic [31:0]           m_axis_tdata;
    // [0] byte_valid, [1] decision_valid, [4:2] file_kind
    logic [4:0]            m_axis_tuser;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // idle rates in percent and the long receiver hold-off
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic rx_hold     = 1'b0;

    // predictor copy of the settings and of the extraction state
    t_cfg                    cfg;
    logic [7:0]              acc;
    int                      acc_bits;
    logic [LSE_INDEX_BITS-1:0] byte_count;
    logic [7:0]              lead_bytes [4];
    int                      lead_count;
    logic [15:0]             row_count;
    logic [1:0]              img_phase;

    t_result expected_results [$];

    int pixels_sent     = 0;
    int results_checked = 0;
    int decisions       = 0;
    int mismatches      = 0;
    int kind_seen [6]   = '{default: 0};

    lsb_stego_extractor_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // byte position feeding bit k of a pixel, selector three folds onto two
    function automatic logic [1:0] lane_of(input int k);
        logic [1:0] s;
        s = (k == 0) ? cfg.first_channel : (k == 1) ? cfg.second_channel : cfg.third_channel;
        return (s == 2'd3) ? 2'd2 : s;
    endfunction

    function automatic int lanes_per_pixel();
        return (cfg.channel_count == 2'd0) ? 1 : int'(cfg.channel_count);
    endfunction

    function automatic void clear_extraction_state();
        acc        = '0;
        acc_bits   = 0;
        byte_count = '0;
        lead_bytes = '{default: 8'h00};
        lead_count = 0;
        row_count  = '0;
        img_phase  = PH_FIRST_ROW;
    endfunction

    // advances the predicted state by one pixel, returns 1 when a result is due
    function automatic bit extract_pixel(input t_pixel pix, output t_result res);
        logic [15:0] row_len;
        logic [31:0] lead;
        logic [2:0]  kind;
        bit          got_byte;
        bit          decided;
        res      = '0;
        got_byte = 1'b0;
        decided  = 1'b0;
        if (pix.image_start) clear_extraction_state();
        if (img_phase == PH_REJECTED) return 1'b0;
        for (int k = 0; k < lanes_per_pixel(); k++) begin
            acc = {acc[6:0], pix[8 * lane_of(k)]};
            acc_bits++;
            if (acc_bits == 8) begin
                got_byte           = 1'b1;
                res.byte_valid     = 1'b1;
                res.extracted_byte = acc;
                res.byte_index     = byte_count;
                // only the first four bytes of an image feed the header match
                if (lead_count < 4) begin
                    lead_bytes[lead_count] = acc;
                    lead_count++;
                end
                byte_count++;
                acc_bits = 0;
                acc      = '0;
            end
        end
        if (img_phase == PH_FIRST_ROW) begin
            row_len = (cfg.row_pixels == 16'd0) ? 16'd1 : cfg.row_pixels;
            row_count++;
            if (row_count >= row_len) begin
                decided = 1'b1;
                lead    = {lead_bytes[3], lead_bytes[2], lead_bytes[1], lead_bytes[0]};
                // fixed priority: three-byte headers first, then bmp, then four-byte ones
                if (lead[23:0] == SIG_JPEG)      kind = KIND_JPEG;
                else if (lead[23:0] == SIG_MP3)  kind = KIND_MP3;
                else if (lead[15:0] == SIG_BMP)  kind = KIND_BMP;
                else if (lead == SIG_PDF)        kind = KIND_PDF;
                else if (lead == SIG_DOCX)       kind = KIND_DOCX;
                else                             kind = KIND_NONE;
                img_phase          = (kind != KIND_NONE) ? PH_ACCEPTED : PH_REJECTED;
                res.decision_valid = 1'b1;
                res.file_kind      = kind;
            end
        end
        return got_byte || decided;
    endfunction

    // leading four bytes of a hidden file of the given kind, free bytes random
    function automatic logic [31:0] signature_lead(input logic [2:0] kind);
        case (kind)
            KIND_JPEG: return {8'($urandom), SIG_JPEG};
            KIND_MP3:  return {8'($urandom), SIG_MP3};
            KIND_BMP:  return {16'($urandom), SIG_BMP};
            KIND_PDF:  return SIG_PDF;
            KIND_DOCX: return SIG_DOCX;
            default:   return $urandom;
        endcase
    endfunction

    // offer one pixel, wait for the handshake, then book its expected result
    task automatic drive_pixel(input t_pixel pix, input bit typed, input t_result typed_res);
        t_result res;
        bit      has_res;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix[23:0];
        s_axis_tuser  <= pix.image_start;
        do @(posedge i_clk); while (!s_axis_tready);
        pixels_sent++;
        has_res = extract_pixel(pix, res);
        if (typed) expected_results.push_back(typed_res);
        else if (has_res) expected_results.push_back(res);
    endtask

    // stop offering and let every outstanding result come out
    task automatic wait_until_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        wait_until_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CHANNEL_COUNT:  cfg.channel_count  = value[1:0];
            REG_FIRST_CHANNEL:  cfg.first_channel  = value[1:0];
            REG_SECOND_CHANNEL: cfg.second_channel = value[1:0];
            REG_THIRD_CHANNEL:  cfg.third_channel  = value[1:0];
            REG_ROW_PIXELS:     cfg.row_pixels     = value[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [1:0] count, input logic [1:0] s0,
                                  input logic [1:0] s1, input logic [1:0] s2,
                                  input logic [15:0] rows);
        write_reg(REG_CHANNEL_COUNT, 32'(count));
        write_reg(REG_FIRST_CHANNEL, 32'(s0));
        write_reg(REG_SECOND_CHANNEL, 32'(s1));
        write_reg(REG_THIRD_CHANNEL, 32'(s2));
        write_reg(REG_ROW_PIXELS, 32'(rows));
    endtask

    // hides the lead bytes msb first in the pixel lsbs, random bits after them
    task automatic send_image(input logic [31:0] lead, input int n_pix);
        int          pos;
        logic [23:0] data;
        logic        start;
        pos = 0;
        for (int n = 0; n < n_pix; n++) begin
            data = 24'($urandom);
            for (int k = 0; k < lanes_per_pixel(); k++) begin
                data[8 * lane_of(k)] = (pos < 32) ? lead[8 * (pos / 8) + 7 - pos % 8]
                                                  : 1'($urandom);
                pos++;
            end
            // now and then a stray image start in mid-image
            start = (n == 0) || ($urandom_range(0, 149) == 0);
            drive_pixel(t_pixel'({start, data}), 1'b0, '0);
        end
    endtask

    // images with random settings and content, mostly well-formed headers
    task automatic random_images(input int quota);
        int          stop_at;
        int          pick;
        int          eff;
        int          need;
        int          rows;
        int          n_pix;
        int          j;
        logic [1:0]  count;
        logic [1:0]  sel [3];
        logic [1:0]  tmp;
        logic [31:0] lead;
        stop_at = pixels_sent + quota;
        while (pixels_sent < stop_at) begin
            pick  = $urandom_range(0, 9);
            count = (pick == 0) ? 2'd0 : 2'((pick % 3) + 1);
            eff   = (count == 2'd0) ? 1 : int'(count);
            need  = (32 + eff - 1) / eff;
            // shuffled distinct lanes, sometimes a folded selector or a duplicate
            sel = '{2'd0, 2'd1, 2'd2};
            for (int i = 2; i > 0; i--) begin
                j      = $urandom_range(0, i);
                tmp    = sel[i];
                sel[i] = sel[j];
                sel[j] = tmp;
            end
            if ($urandom_range(0, 4) == 0) begin
                foreach (sel[i]) if (sel[i] == 2'd2) sel[i] = 2'd3;
            end
            if ($urandom_range(0, 9) == 0) sel[$urandom_range(0, 2)] = 2'($urandom_range(0, 3));
            // short first rows, endless first rows, or rows that hold the header
            pick = $urandom_range(0, 9);
            if (pick == 0)      rows = $urandom_range(0, need - 1);
            else if (pick == 1) rows = 65535;
            else                rows = need + $urandom_range(0, 5);
            n_pix = (rows == 65535) ? 24 : ((rows == 0) ? 1 : rows) + $urandom_range(0, 12);
            // noise, a proper header, or a header with one bit broken
            pick = $urandom_range(0, 6);
            if (pick == 0)      lead = $urandom;
            else if (pick == 6) lead = signature_lead(3'($urandom_range(1, 5))) ^
                                       (32'd1 << $urandom_range(0, 31));
            else                lead = signature_lead(3'(pick));
            apply_settings(count, sel[0], sel[1], sel[2], 16'(rows));
            send_image(lead, n_pix);
            if ($urandom_range(0, 3) == 0) begin
                repeat (8) drive_pixel(t_pixel'({$urandom_range(0, 5) == 0, 24'($urandom)}),
                                       1'b0, '0);
            end
        end
    endtask

    // result side: random backpressure and in-order comparison
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.byte_valid     = m_axis_tuser[0];
            got.decision_valid = m_axis_tuser[1];
            got.file_kind      = m_axis_tuser[4:2];
            got.extracted_byte = m_axis_tdata[7:0];
            got.byte_index     = m_axis_tdata[31:8];
            results_checked++;
            if (got.decision_valid) begin
                decisions++;
                if (got.file_kind <= KIND_DOCX) kind_seen[got.file_kind]++;
            end
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: bv %0b byte %h idx %h dv %0b kind %0d",
                             got.byte_valid, got.extracted_byte, got.byte_index,
                             got.decision_valid, got.file_kind);
            end else begin
                want = expected_results.pop_front();
                if (got.byte_valid !== want.byte_valid ||
                    got.extracted_byte !== want.extracted_byte ||
                    got.byte_index !== want.byte_index ||
                    got.decision_valid !== want.decision_valid ||
                    got.file_kind !== want.file_kind) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result %0d: got bv %0b byte %h idx %h dv %0b kind %0d",
                                 results_checked, got.byte_valid, got.extracted_byte,
                                 got.byte_index, got.decision_valid, got.file_kind);
                        $display("           want bv %0b byte %h idx %h dv %0b kind %0d",
                                 want.byte_valid, want.extracted_byte, want.byte_index,
                                 want.decision_valid, want.file_kind);
                    end
                end
            end
        end
        m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    initial begin
        t_dir_row row;
        t_result  typed_res;
        int       waited;
        cfg = '{2'd1, 2'd0, 2'd1, 2'd2, 16'd1};
        clear_extraction_state();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table and first random images with a slow receiver
        tx_idle_pct = 33;
        rx_idle_pct = 79;
        for (int i = 0; i < DIR_ROWS; i++) begin
            row = DIRECTED[i];
            if (row.op == ROW_WRITE) begin
                write_reg(row.reg_idx, 32'(row.value));
            end else begin
                typed_res                = '0;
                typed_res.file_kind      = row.exp_user[4:2];
                typed_res.decision_valid = row.exp_user[1];
                typed_res.byte_valid     = row.exp_user[0];
                drive_pixel(t_pixel'({row.start, row.data}), row.op == ROW_TYPED, typed_res);
            end
        end

        // random images: slow receiver, then slow sender, then full rate
        random_images(110);
        tx_idle_pct = 79;
        rx_idle_pct = 33;
        random_images(110);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_images(70);

        // receiver stalls for a long stretch while a byte-dense image keeps coming
        apply_settings(2'd3, 2'd0, 2'd1, 2'd2, 16'd40);
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
            send_image(signature_lead(KIND_DOCX), 60);
        join

        // bounded wait for the tail, leftovers count as failures
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < END_WAIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            mismatches += expected_results.size();
            $display("%0d expected results never arrived", expected_results.size());
        end

        $display("%0d pixels fed, %0d results compared, %0d header decisions, %0d failures",
                 pixels_sent, results_checked, decisions, mismatches);
        $display("decisions by kind: none %0d jpeg %0d mp3 %0d bmp %0d pdf %0d docx %0d",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
                 kind_seen[5]);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

endmodule
